FILE: sv/vbpp_pkg.sv
// Shared types and constants for the variable block page placer.
// Used by vbpp_ctrl, vbpp_datapath and variable_block_page_placer_core.
`timescale 1ns / 1ps
`default_nettype none

package vbpp_pkg;

    // Field widths
    localparam int OP_W        = 1;
    localparam int SIZE_W      = 24;
    localparam int PSZ_W       = 16;
    localparam int LIMIT_W     = 17;
    localparam int IDX_W       = 10;
    localparam int PAGE_W      = 16;
    localparam int PAGES_W     = 17;
    localparam int STATUS_W    = 3;
    localparam int POS_W       = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 17;

    // Block slots
    localparam int MAX_BLOCKS  = 1024;
    localparam int COUNT_W     = $clog2(MAX_BLOCKS + 1);

    localparam logic [LIMIT_W-1:0] PAGE_LIMIT_CAP   = LIMIT_W'(65536);
    localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RESET = LIMIT_W'(4096);

    // Serial divider: dividend covers end position plus one block
    localparam int DIV_W       = POS_W + 1;
    localparam int DIV_STEPS   = DIV_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_ADD   = 1'b0;
    localparam logic [OP_W-1:0] OP_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_PSZ    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_PAGES  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NO_SLOTS  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } vbpp_state_t;

    typedef struct packed {
        logic load;    // latch request, seed both dividers
        logic step;    // one divider iteration
        logic commit;  // update placement, load result register
    } vbpp_cmd_t;

endpackage

`default_nettype wire

FILE: sv/variable_block_page_placer_core.sv
// Variable block page placer: controller plus datapath.
// Flow: a request is latched on accept, runs through the bit-serial divider, then commits.
// No new request is taken until the last one commits; commit waits for a free result register.
// The result register frees the input side; the next request is taken while a result waits.
// Reset: async active low; page_size 0, page_limit 4096, placement empty.
`timescale 1ns / 1ps
`default_nettype none

module variable_block_page_placer_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vbpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vbpp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [vbpp_pkg::OP_W-1:0]          operation,
    input  wire logic [vbpp_pkg::SIZE_W-1:0]        block_size,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [vbpp_pkg::IDX_W-1:0]              block_index,
    output logic [vbpp_pkg::PAGE_W-1:0]             start_page,
    output logic [vbpp_pkg::PSZ_W-1:0]              start_offset,
    output logic [vbpp_pkg::PAGES_W-1:0]            first_owned_page,
    output logic [vbpp_pkg::PAGES_W-1:0]            owned_pages,
    output logic [vbpp_pkg::PAGES_W-1:0]            pages_used,
    output logic [vbpp_pkg::PSZ_W-1:0]              end_offset,
    output logic [vbpp_pkg::STATUS_W-1:0]           status
);
    import vbpp_pkg::*;

    vbpp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    vbpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    vbpp_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .operation        (operation),
        .block_size       (block_size),
        .block_index      (block_index),
        .start_page       (start_page),
        .start_offset     (start_offset),
        .first_owned_page (first_owned_page),
        .owned_pages      (owned_pages),
        .pages_used       (pages_used),
        .end_offset       (end_offset),
        .status           (status)
    );

    // controller goes busy right after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // a fresh result appears only from a commit
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(cmd.commit))
        else $error("result valid without commit");

    // accepted block owns exactly the pages between its first owned page and the end
    a_owned_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_OK && block_size != '0 && operation == OP_ADD
        && owned_pages != '0 |-> (first_owned_page + owned_pages) == pages_used)
        else $error("owned page span mismatch");

    // rejected block reports no placement
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> block_index == '0 && start_page == '0
        && start_offset == '0 && owned_pages == '0 && first_owned_page == '0)
        else $error("rejected block has placement fields");

endmodule

`default_nettype wire

FILE: sv/vbpp_ctrl.sv
// Controller for the page placer: sequences load, divide and commit.
// Depends on vbpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbpp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output vbpp_pkg::vbpp_cmd_t     cmd
);
    import vbpp_pkg::*;

    vbpp_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: sv/vbpp_datapath.sv
// Datapath for the page placer: config registers, placement state,
// two bit-serial dividers and the result register. Depends on vbpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vbpp_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire vbpp_pkg::vbpp_cmd_t                cmd,
    input  wire logic                               cfg_we,
    input  wire logic [vbpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [vbpp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [vbpp_pkg::OP_W-1:0]          operation,
    input  wire logic [vbpp_pkg::SIZE_W-1:0]        block_size,
    output logic [vbpp_pkg::IDX_W-1:0]              block_index,
    output logic [vbpp_pkg::PAGE_W-1:0]             start_page,
    output logic [vbpp_pkg::PSZ_W-1:0]              start_offset,
    output logic [vbpp_pkg::PAGES_W-1:0]            first_owned_page,
    output logic [vbpp_pkg::PAGES_W-1:0]            owned_pages,
    output logic [vbpp_pkg::PAGES_W-1:0]            pages_used,
    output logic [vbpp_pkg::PSZ_W-1:0]              end_offset,
    output logic [vbpp_pkg::STATUS_W-1:0]           status
);
    import vbpp_pkg::*;

    // config and placement state
    logic [PSZ_W-1:0]    page_size_reg;
    logic [LIMIT_W-1:0]  page_limit_reg;
    logic [COUNT_W-1:0]  block_count_reg, block_count_next;
    logic [POS_W-1:0]    end_pos_reg, end_pos_next;

    // latched request
    logic [OP_W-1:0]     op_reg;
    logic [SIZE_W-1:0]   size_reg;

    // divider lanes: s = current end, n = end after this block
    logic [PSZ_W-1:0]    rem_s_reg, rem_n_reg;
    logic [DIV_W-1:0]    quo_s_reg, quo_n_reg;
    logic [PSZ_W-1:0]    rem_s_next, rem_n_next;
    logic [DIV_W-1:0]    quo_s_next, quo_n_next;

    // result
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PAGE_W-1:0]   spage_reg, spage_next;
    logic [PSZ_W-1:0]    soff_reg, soff_next;
    logic [PAGES_W-1:0]  first_reg, first_next;
    logic [PAGES_W-1:0]  owned_reg, owned_next;
    logic [PAGES_W-1:0]  used_reg, used_next;
    logic [PSZ_W-1:0]    endoff_reg, endoff_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [DIV_W:0]      cur_used, new_used;
    logic [LIMIT_W-1:0]  lim;
    logic                rs_nz, rn_nz, psz_zero, pages_over;
    logic [PSZ_W-1:0]    s_endoff;
    logic [POS_W-1:0]    n_pos;

    // restoring division step, remainder kept below divisor
    function automatic logic [PSZ_W+DIV_W-1:0] div_step(
        input logic [PSZ_W-1:0] rem,
        input logic [DIV_W-1:0] quo,
        input logic [PSZ_W-1:0] dvs
    );
        logic [PSZ_W:0] rem_sh;
        logic [PSZ_W:0] diff;
        logic           ge;
        rem_sh = {rem, quo[DIV_W-1]};
        diff   = rem_sh - {1'b0, dvs};
        ge     = (rem_sh >= {1'b0, dvs});
        return {(ge ? diff[PSZ_W-1:0] : rem_sh[PSZ_W-1:0]), quo[DIV_W-2:0], ge};
    endfunction

    always_comb
    begin
        rem_s_next = rem_s_reg;
        quo_s_next = quo_s_reg;
        rem_n_next = rem_n_reg;
        quo_n_next = quo_n_reg;
        if (cmd.load)
        begin
            rem_s_next = '0;
            rem_n_next = '0;
            quo_s_next = {1'b0, end_pos_reg};
            quo_n_next = {1'b0, end_pos_reg} + {{(DIV_W-SIZE_W){1'b0}}, block_size};
        end
        else if (cmd.step)
        begin
            {rem_s_next, quo_s_next} = div_step(rem_s_reg, quo_s_reg, page_size_reg);
            {rem_n_next, quo_n_next} = div_step(rem_n_reg, quo_n_reg, page_size_reg);
        end
    end

    // commit decision
    always_comb
    begin
        psz_zero   = (page_size_reg == '0);
        rs_nz      = (rem_s_reg != '0);
        rn_nz      = (rem_n_reg != '0);
        cur_used   = {1'b0, quo_s_reg} + {{DIV_W{1'b0}}, rs_nz};
        new_used   = {1'b0, quo_n_reg} + {{DIV_W{1'b0}}, rn_nz};
        lim        = (page_limit_reg > PAGE_LIMIT_CAP) ? PAGE_LIMIT_CAP : page_limit_reg;
        pages_over = (new_used > {{(DIV_W+1-LIMIT_W){1'b0}}, lim});
        n_pos      = end_pos_reg + {{(POS_W-SIZE_W){1'b0}}, size_reg};
        if (rs_nz)
            s_endoff = rem_s_reg;
        else if (end_pos_reg == '0)
            s_endoff = '0;
        else
            s_endoff = page_size_reg;

        block_count_next = block_count_reg;
        end_pos_next     = end_pos_reg;
        idx_next         = '0;
        spage_next       = '0;
        soff_next        = '0;
        first_next       = '0;
        owned_next       = '0;
        used_next        = '0;
        endoff_next      = '0;
        status_next      = STATUS_OK;

        if (op_reg == OP_CLEAR)
        begin
            block_count_next = '0;
            end_pos_next     = '0;
        end
        else
        begin
            if (!psz_zero)
            begin
                used_next   = cur_used[PAGES_W-1:0];
                endoff_next = s_endoff;
            end
            if (size_reg == '0)
                status_next = STATUS_ZERO_SIZE;
            else if (psz_zero)
                status_next = STATUS_NO_PSZ;
            else if (block_count_reg >= COUNT_W'(MAX_BLOCKS))
                status_next = STATUS_NO_SLOTS;
            else if (pages_over)
                status_next = STATUS_NO_PAGES;
            else
            begin
                idx_next         = block_count_reg[IDX_W-1:0];
                spage_next       = quo_s_reg[PAGE_W-1:0];
                soff_next        = rem_s_reg;
                first_next       = cur_used[PAGES_W-1:0];
                owned_next       = new_used[PAGES_W-1:0] - cur_used[PAGES_W-1:0];
                used_next        = new_used[PAGES_W-1:0];
                endoff_next      = rn_nz ? rem_n_reg : page_size_reg;
                block_count_next = block_count_reg + COUNT_W'(1);
                end_pos_next     = n_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg   <= '0;
            page_limit_reg  <= PAGE_LIMIT_RESET;
            block_count_reg <= '0;
            end_pos_reg     <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_PAGE_SIZE)
                page_size_reg <= cfg_data[PSZ_W-1:0];
            if (cfg_we && cfg_index == CFG_PAGE_LIMIT)
                page_limit_reg <= cfg_data[LIMIT_W-1:0];
            if (cmd.commit)
            begin
                block_count_reg <= block_count_next;
                end_pos_reg     <= end_pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_s_reg <= rem_s_next;
        quo_s_reg <= quo_s_next;
        rem_n_reg <= rem_n_next;
        quo_n_reg <= quo_n_next;
        if (cmd.load)
        begin
            op_reg   <= operation;
            size_reg <= block_size;
        end
        if (cmd.commit)
        begin
            idx_reg    <= idx_next;
            spage_reg  <= spage_next;
            soff_reg   <= soff_next;
            first_reg  <= first_next;
            owned_reg  <= owned_next;
            used_reg   <= used_next;
            endoff_reg <= endoff_next;
            status_reg <= status_next;
        end
    end

    assign block_index      = idx_reg;
    assign start_page       = spage_reg;
    assign start_offset     = soff_reg;
    assign first_owned_page = first_reg;
    assign owned_pages      = owned_reg;
    assign pages_used       = used_reg;
    assign end_offset       = endoff_reg;
    assign status           = status_reg;

endmodule

`default_nettype wire
